[src/char_lcd_frame_buffer_refresher_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD frame buffer refresher.
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_FRAME_BUFFER_REFRESHER_MACROS_SVH
`define CHAR_LCD_FRAME_BUFFER_REFRESHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CLFB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clfb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clfb assertion failed");

`else

`define CLFB_ASSERT_SAME(label, clk, rst, ante, cons)
`define CLFB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/clfb_pkg.sv]
// ----------------------------------------------------------------------------
// clfb_pkg
// Shared types, constants and helpers of the character LCD frame buffer
// refresher: geometry, command bytes, operation codes and controller states.
// ----------------------------------------------------------------------------
package clfb_pkg;

  // Display geometry.
  localparam int LINES   = 2;
  localparam int COLUMNS = 16;
  localparam int DEPTH   = LINES * COLUMNS;

  localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROOM_W = $clog2(COLUMNS + 1);

  // Configuration register file.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BACKLIGHT_MASK   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_MODE_CMD   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FUNCTION_SET_CMD = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DISPLAY_CTRL_CMD = 3'd4;

  localparam logic [7:0] RST_ENABLE_MASK      = 8'h04;
  localparam logic [7:0] RST_BACKLIGHT_MASK   = 8'h08;
  localparam logic [7:0] RST_ENTRY_MODE_CMD   = 8'h06;
  localparam logic [7:0] RST_FUNCTION_SET_CMD = 8'h28;
  localparam logic [7:0] RST_DISPLAY_CTRL_CMD = 8'h0C;

  // LCD command bytes and character constants.
  localparam logic [7:0] CMD_WAKE     = 8'h03;
  localparam logic [7:0] CMD_FOUR_BIT = 8'h02;
  localparam logic [7:0] CMD_LINE0    = 8'h80;
  localparam logic [7:0] CMD_LINE1    = 8'hC0;
  localparam logic [7:0] TAIL_CMD     = (LINES > 1) ? CMD_LINE1 : CMD_LINE0;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] NIBBLE_MASK  = 8'hF0;

  // Reset sequence length.
  localparam int SEQ_LEN = 7;
  localparam int SEQ_W   = $clog2(SEQ_LEN);

  // Input operation codes.
  typedef enum logic [2:0] {
    OP_INIT       = 3'd0,
    OP_REINIT     = 3'd1,
    OP_SET_CURSOR = 3'd2,
    OP_PUT_CHAR   = 3'd3,
    OP_STRING     = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_REFRESH    = 3'd6
  } clfb_op_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RESET_SEQ,
    S_REF_HEAD,
    S_REF_CHAR,
    S_REF_TAIL
  } clfb_state_t;

  // One LCD byte handed from the controller to the encoder.
  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
  } clfb_byte_t;

  // Buffer address of a line and column.
  function automatic logic [ADDR_W-1:0] text_addr(input logic [LINE_W-1:0] ln,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W+LINE_W+7:0] full;
    full = (ADDR_W+LINE_W+8)'(ln) * (ADDR_W+LINE_W+8)'(COLUMNS)
         + (ADDR_W+LINE_W+8)'(col);
    return full[ADDR_W-1:0];
  endfunction

endpackage

[src/char_lcd_frame_buffer_refresher.sv]
// ----------------------------------------------------------------------------
// char_lcd_frame_buffer_refresher
// Character LCD front end: a 2x16 text buffer with cursor, emitting the
// reset sequence and full-screen refreshes as 4-bit expander writes.
//
//   channel   signals                                      direction
//   in        in_valid/in_ready, op, line, column,
//             char_code, string_start                      sink
//   out       out_valid/out_ready, expander_writes,
//             lcd_byte, is_data, last                      source
//   cfg       cfg_write, cfg_index, cfg_data               sink, no wait
//
// Init and reinit give 7 results and a refresh 35, one per cycle while
// out_ready is high; the single output register sets that pace. A refresh
// reads the buffer memory one cell ahead. After reset the buffer reads as
// spaces at once through per-entry valid bits, with no clearing pass. A
// stalled sink holds the sequencer in place.
// ----------------------------------------------------------------------------
`include "char_lcd_frame_buffer_refresher_macros.svh"

module char_lcd_frame_buffer_refresher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      op,
  input  logic [7:0]                      line,
  input  logic [7:0]                      column,
  input  logic [7:0]                      char_code,
  input  logic                            string_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [47:0]                     expander_writes,
  output logic [7:0]                      lcd_byte,
  output logic                            is_data,
  output logic                            last,
  input  logic                            cfg_write,
  input  logic [clfb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);

  localparam logic [clfb_pkg::COL_W-1:0]  LAST_COL  = clfb_pkg::COL_W'(clfb_pkg::COLUMNS - 1);
  localparam logic [clfb_pkg::LINE_W-1:0] LAST_LINE = clfb_pkg::LINE_W'(clfb_pkg::LINES - 1);
  localparam logic [clfb_pkg::SEQ_W-1:0]  LAST_SEQ  = clfb_pkg::SEQ_W'(clfb_pkg::SEQ_LEN - 1);

  clfb_pkg::clfb_state_t state, state_next;

  logic [7:0] enable_mask, backlight_mask, entry_mode_cmd, function_set_cmd;
  logic [7:0] display_control_cmd;

  logic [clfb_pkg::LINE_W-1:0] cursor_line, cursor_line_next;
  logic [clfb_pkg::COL_W-1:0]  cursor_column, cursor_column_next;
  logic [clfb_pkg::ROOM_W-1:0] string_room, string_room_next;
  logic [clfb_pkg::ROOM_W-1:0] room_avail;

  logic [clfb_pkg::SEQ_W-1:0]  seq_count, seq_count_next;
  logic [clfb_pkg::LINE_W-1:0] ref_line, ref_line_next;
  logic [clfb_pkg::COL_W-1:0]  ref_col, ref_col_next;

  logic                 accept;
  logic                 push;
  logic                 can_push;
  clfb_pkg::clfb_byte_t push_byte;
  logic                 buf_clear;
  logic                 buf_wr;
  logic [7:0]           rd_data;
  logic [7:0]           seq_byte;

  assign accept = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask         <= clfb_pkg::RST_ENABLE_MASK;
      backlight_mask      <= clfb_pkg::RST_BACKLIGHT_MASK;
      entry_mode_cmd      <= clfb_pkg::RST_ENTRY_MODE_CMD;
      function_set_cmd    <= clfb_pkg::RST_FUNCTION_SET_CMD;
      display_control_cmd <= clfb_pkg::RST_DISPLAY_CTRL_CMD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        clfb_pkg::REG_ENABLE_MASK:      enable_mask         <= cfg_data;
        clfb_pkg::REG_BACKLIGHT_MASK:   backlight_mask      <= cfg_data;
        clfb_pkg::REG_ENTRY_MODE_CMD:   entry_mode_cmd      <= cfg_data;
        clfb_pkg::REG_FUNCTION_SET_CMD: function_set_cmd    <= cfg_data;
        clfb_pkg::REG_DISPLAY_CTRL_CMD: display_control_cmd <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state and sequencer counters.
  always_comb begin
    state_next     = state;
    seq_count_next = seq_count;
    ref_line_next  = ref_line;
    ref_col_next   = ref_col;
    unique case (state)
      clfb_pkg::S_IDLE: begin
        seq_count_next = '0;
        ref_line_next  = '0;
        ref_col_next   = '0;
        if (in_valid) begin
          if (op == clfb_pkg::OP_INIT || op == clfb_pkg::OP_REINIT) begin
            state_next = clfb_pkg::S_RESET_SEQ;
          end else if (op == clfb_pkg::OP_REFRESH) begin
            state_next = clfb_pkg::S_REF_HEAD;
          end
        end
      end
      clfb_pkg::S_RESET_SEQ: begin
        if (can_push) begin
          if (seq_count == LAST_SEQ) begin
            state_next = clfb_pkg::S_IDLE;
          end else begin
            seq_count_next = seq_count + 1'b1;
          end
        end
      end
      clfb_pkg::S_REF_HEAD: begin
        if (can_push) begin
          state_next = clfb_pkg::S_REF_CHAR;
        end
      end
      clfb_pkg::S_REF_CHAR: begin
        if (can_push) begin
          if (ref_col == LAST_COL) begin
            state_next = clfb_pkg::S_REF_TAIL;
          end else begin
            ref_col_next = ref_col + 1'b1;
          end
        end
      end
      clfb_pkg::S_REF_TAIL: begin
        if (can_push) begin
          ref_col_next = '0;
          if (ref_line == LAST_LINE) begin
            state_next = clfb_pkg::S_IDLE;
          end else begin
            ref_line_next = ref_line + 1'b1;
            state_next    = clfb_pkg::S_REF_CHAR;
          end
        end
      end
      default: state_next = clfb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= clfb_pkg::S_IDLE;
      seq_count <= '0;
      ref_line  <= '0;
      ref_col   <= '0;
    end else begin
      state     <= state_next;
      seq_count <= seq_count_next;
      ref_line  <= ref_line_next;
      ref_col   <= ref_col_next;
    end
  end

  // Byte of the reset sequence at the current step.
  always_comb begin
    unique case (seq_count)
      3'd0, 3'd1, 3'd2: seq_byte = clfb_pkg::CMD_WAKE;
      3'd3:             seq_byte = clfb_pkg::CMD_FOUR_BIT;
      3'd4:             seq_byte = entry_mode_cmd;
      3'd5:             seq_byte = function_set_cmd;
      default:          seq_byte = display_control_cmd;
    endcase
  end

  // Outputs of the sequencer toward the encoder.
  always_comb begin
    in_ready  = 1'b0;
    push      = 1'b0;
    push_byte = '{data: clfb_pkg::CMD_LINE0, is_data: 1'b0, last: 1'b0};
    unique case (state)
      clfb_pkg::S_IDLE: in_ready = 1'b1;
      clfb_pkg::S_RESET_SEQ: begin
        push      = 1'b1;
        push_byte = '{data: seq_byte, is_data: 1'b0, last: seq_count == LAST_SEQ};
      end
      clfb_pkg::S_REF_HEAD: begin
        push      = 1'b1;
        push_byte = '{data: clfb_pkg::CMD_LINE0, is_data: 1'b0, last: 1'b0};
      end
      clfb_pkg::S_REF_CHAR: begin
        push      = 1'b1;
        push_byte = '{data: rd_data, is_data: 1'b1, last: 1'b0};
      end
      clfb_pkg::S_REF_TAIL: begin
        push      = 1'b1;
        push_byte = '{data: clfb_pkg::TAIL_CMD, is_data: 1'b0,
                      last: ref_line == LAST_LINE};
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Cursor, string room and buffer writes of the silent operations.
  always_comb begin
    cursor_line_next   = cursor_line;
    cursor_column_next = cursor_column;
    string_room_next   = string_room;
    buf_clear          = 1'b0;
    buf_wr             = 1'b0;
    room_avail = string_start
               ? clfb_pkg::ROOM_W'(clfb_pkg::COLUMNS) - clfb_pkg::ROOM_W'(cursor_column)
               : string_room;
    if (accept) begin
      unique case (op)
        clfb_pkg::OP_INIT, clfb_pkg::OP_CLEAR: begin
          buf_clear          = 1'b1;
          cursor_line_next   = '0;
          cursor_column_next = '0;
        end
        clfb_pkg::OP_SET_CURSOR: begin
          cursor_line_next   = (line >= 8'(clfb_pkg::LINES - 1))
                             ? LAST_LINE : line[clfb_pkg::LINE_W-1:0];
          cursor_column_next = (column >= 8'(clfb_pkg::COLUMNS - 1))
                             ? LAST_COL : column[clfb_pkg::COL_W-1:0];
        end
        clfb_pkg::OP_PUT_CHAR: begin
          buf_wr = 1'b1;
        end
        clfb_pkg::OP_STRING: begin
          // A zero byte ends the string; otherwise store while room is left.
          if (char_code == 8'h00) begin
            string_room_next = '0;
          end else if (room_avail != '0) begin
            buf_wr           = 1'b1;
            string_room_next = room_avail - 1'b1;
          end else begin
            string_room_next = room_avail;
          end
        end
        default: ;
      endcase
      if (buf_wr && cursor_column != LAST_COL) begin
        cursor_column_next = cursor_column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_line   <= '0;
      cursor_column <= '0;
      string_room   <= '0;
    end else begin
      cursor_line   <= cursor_line_next;
      cursor_column <= cursor_column_next;
      string_room   <= string_room_next;
    end
  end

  // Buffer memory; the read runs one cell ahead of the refresh walk.
  clfb_text_store u_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (buf_clear),
    .wr_en   (buf_wr),
    .wr_addr (clfb_pkg::text_addr(cursor_line, cursor_column)),
    .wr_data (char_code),
    .rd_addr (clfb_pkg::text_addr(ref_line_next, ref_col_next)),
    .rd_data (rd_data)
  );

  // Expander encoding and output register.
  clfb_byte_encoder u_encoder (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .push_byte       (push_byte),
    .can_push        (can_push),
    .enable_mask     (enable_mask),
    .backlight_mask  (backlight_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .expander_writes (expander_writes),
    .lcd_byte        (lcd_byte),
    .is_data         (is_data),
    .last            (last)
  );

  // A final byte handed to the encoder returns the controller to idle.
  `CLFB_ASSERT_NEXT(a_last_ends_item, clk, rst, push && can_push && push_byte.last, state == clfb_pkg::S_IDLE)

  // The refresh walk never leaves the buffer.
  `CLFB_ASSERT_SAME(a_ref_col_range, clk, rst, state == clfb_pkg::S_REF_CHAR, ref_col <= LAST_COL)

  // Cursor and string room stay within the line.
  `CLFB_ASSERT_SAME(a_cursor_range, clk, rst, 1'b1, cursor_column <= LAST_COL && string_room <= clfb_pkg::ROOM_W'(clfb_pkg::COLUMNS))

  // A refresh transaction starts with the home cursor command.
  `CLFB_ASSERT_NEXT(a_refresh_starts, clk, rst, accept && op == clfb_pkg::OP_REFRESH, state == clfb_pkg::S_REF_HEAD)

endmodule

[src/clfb_text_store.sv]
// ----------------------------------------------------------------------------
// clfb_text_store
// Text buffer memory with one write port and one registered read port.
// Per-entry valid bits make every unwritten entry read as a space.
// ----------------------------------------------------------------------------
module clfb_text_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       wr_en,
  input  logic [clfb_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic [clfb_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                 rd_data
);

  logic [7:0]                 mem [clfb_pkg::DEPTH];
  logic [clfb_pkg::DEPTH-1:0] valid;
  logic [7:0]                 rd_q;
  logic                       rd_valid;

  // Storage array and its registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Valid bits: cleared at reset and by a buffer clear.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
    end
  end

  // An entry never written since the last clear holds a space.
  assign rd_data = rd_valid ? rd_q : clfb_pkg::SPACE_CHAR;

endmodule

[src/clfb_byte_encoder.sv]
// ----------------------------------------------------------------------------
// clfb_byte_encoder
// Turns one LCD byte into the six expander writes of 4-bit mode and holds
// the result in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module clfb_byte_encoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  clfb_pkg::clfb_byte_t push_byte,
  output logic                 can_push,
  input  logic [7:0]           enable_mask,
  input  logic [7:0]           backlight_mask,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [47:0]          expander_writes,
  output logic [7:0]           lcd_byte,
  output logic                 is_data,
  output logic                 last
);

  logic [7:0]  rs_bits;
  logic [7:0]  hi;
  logic [7:0]  lo;
  logic [47:0] pack;

  // Nibble split with register select and backlight ORed in.
  always_comb begin
    rs_bits = {7'b0, push_byte.is_data};
    hi      = rs_bits | (push_byte.data & clfb_pkg::NIBBLE_MASK) | backlight_mask;
    lo      = rs_bits | ({push_byte.data[3:0], 4'b0}) | backlight_mask;
    pack    = {hi, hi | enable_mask, hi & ~enable_mask,
               lo, lo | enable_mask, lo & ~enable_mask};
  end

  // The register is free when empty or being drained this cycle.
  assign can_push = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_push) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && can_push) begin
      expander_writes <= pack;
      lcd_byte        <= push_byte.data;
      is_data         <= push_byte.is_data;
      last            <= push_byte.last;
    end
  end

endmodule
